/* rtl/drs_pkg.sv */
// drs_pkg: types, widths, codes and helpers shared by the range slicer
// no dependencies
`timescale 1ns / 1ps

package drs_pkg;

	localparam int ID_W    = 31;
	localparam int QUOTA_W = 32;
	localparam int TOTAL_W = 33;
	localparam int COUNT_W = 9;
	localparam int INDEX_W = 8;
	localparam int STAT_W  = 2;
	localparam int REG_W   = 1;

	// status codes
	localparam logic [STAT_W-1:0] ST_VALID = 2'd0;
	localparam logic [STAT_W-1:0] ST_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_OVFL  = 2'd3;

	// register indexes
	localparam logic [REG_W-1:0] REG_SLICE_COUNT = 1'b0;
	localparam logic [REG_W-1:0] REG_SLICE_INDEX = 1'b1;

	// saturation point of the running total
	localparam logic [TOTAL_W-1:0] TOTAL_SAT = 33'h1_0000_0000;

	// divider request and response
	typedef struct packed {
		logic               start;
		logic [QUOTA_W-1:0] dividend;
		logic [COUNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [QUOTA_W-1:0] quotient;
		logic [COUNT_W-1:0] remainder;
	} div_rsp_t;

	// size of an inclusive range, zero when reversed
	function automatic logic [QUOTA_W-1:0] range_size(input logic [ID_W-1:0] b,
		input logic [ID_W-1:0] e);
		logic [QUOTA_W-1:0] sz;
		if (e < b) begin
			sz = '0;
		end else begin
			sz = {1'b0, e} - {1'b0, b} + 32'd1;
		end
		return sz;
	endfunction

endpackage

/* rtl/drs_ifs.sv */
// drs_range_if and drs_slice_if: valid/ready channels of the range slicer
// depends on drs_pkg for field widths
`timescale 1ns / 1ps

interface drs_range_if;
	logic                     valid;
	logic                     ready;
	logic [drs_pkg::ID_W-1:0] range_begin;
	logic [drs_pkg::ID_W-1:0] range_end;
	logic                     range_ordered;
	logic                     last_range;

	modport source (output valid, range_begin, range_end, range_ordered, last_range,
		input ready);
	modport sink (input valid, range_begin, range_end, range_ordered, last_range,
		output ready);
endinterface

interface drs_slice_if;
	logic                        valid;
	logic                        ready;
	logic [drs_pkg::ID_W-1:0]    slice_begin;
	logic [drs_pkg::ID_W-1:0]    slice_end;
	logic                        slice_ordered;
	logic [drs_pkg::QUOTA_W-1:0] slice_quota;
	logic [drs_pkg::STAT_W-1:0]  status;
	logic                        last_result;

	modport source (output valid, slice_begin, slice_end, slice_ordered, slice_quota,
		status, last_result, input ready);
	modport sink (input valid, slice_begin, slice_end, slice_ordered, slice_quota,
		status, last_result, output ready);
endinterface

/* rtl/drs_ram.sv */
// drs_ram: generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module drs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/drs_div.sv */
// drs_div: restoring divider, one quotient bit per cycle
// depends on drs_pkg for the request and response structs
`timescale 1ns / 1ps

module drs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  drs_pkg::div_req_t req,
	output drs_pkg::div_rsp_t rsp
);

	localparam int QW = drs_pkg::QUOTA_W;
	localparam int DW = drs_pkg::COUNT_W;
	localparam int CNT_W = $clog2(QW);

	logic            busy_q;
	logic            done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QW-1:0]   quot_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   divisor_q;
	logic [DW:0]     trial;
	logic            fits;

	// trial subtraction of one step
	assign trial = {rem_q, quot_q[QW-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[QW-2:0], fits};
			if (fits) begin
				rem_q <= DW'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DW-1:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

endmodule

/* rtl/docid_range_slice_split.sv */
// docid_range_slice_split: loads document-id ranges and emits one worker's slice
// depends on drs_pkg, drs_ifs, drs_ram and drs_div
//
// channel  dir  transaction
// ranges   in   one inclusive range (begin, end, ordered, last of list)
// slices   out  one sub-range with quota, or a single status result
// wr_*     in   register write: 0 slice_count, 1 slice_index
//
// Ranges load at one per cycle into the range ram while the slicer is in its
// load state; the running total is updated as they arrive. After the last range:
// a check once the output register is free, the serial divider, a multiply step,
// then a ram read and a trim per stored range walked, and a hold after each
// sub-range that is not the last until the output takes it, plus any output stalls.
// Reset clears counters and control; no ram clearing pass is made. New ranges
// are refused during a split, but may load while the final result still waits.
`timescale 1ns / 1ps

module docid_range_slice_split #(
	parameter int MAX_RANGES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	drs_range_if.sink                       ranges,
	drs_slice_if.source                     slices,
	input  logic                            wr_en,
	input  logic [drs_pkg::REG_W-1:0]       wr_index,
	input  logic [drs_pkg::COUNT_W-1:0]     wr_data
);

	localparam int IDW = drs_pkg::ID_W;
	localparam int QW  = drs_pkg::QUOTA_W;
	localparam int TW  = drs_pkg::TOTAL_W;
	localparam int AW  = MAX_RANGES > 1 ? $clog2(MAX_RANGES) : 1;
	localparam int CW  = $clog2(MAX_RANGES + 1);
	localparam int MW  = 2 * IDW + 1;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_PROC  = 3'd5;
	localparam logic [2:0] S_HOLD  = 3'd6;

	logic [2:0]                   state_q;
	logic [drs_pkg::COUNT_W-1:0]  count_q;
	logic [drs_pkg::INDEX_W-1:0]  index_q;
	logic [CW-1:0]                loaded_q;
	logic [TW-1:0]                total_q;
	logic [CW-1:0]                idx_q;
	logic [QW-1:0]                skip_q;
	logic [QW-1:0]                need_q;

	logic                         ovalid_q;
	logic [IDW-1:0]               obegin_q;
	logic [IDW-1:0]               oend_q;
	logic                         oord_q;
	logic [QW-1:0]                oquota_q;
	logic [drs_pkg::STAT_W-1:0]   ostat_q;
	logic                         olast_q;

	logic                         in_fire;
	logic                         store;
	logic [QW-1:0]                in_size;
	logic [TW:0]                  sum_wide;
	logic [TW-1:0]                total_nx;
	logic [MW-1:0]                ram_rdata;
	drs_pkg::div_req_t            div_req;
	drs_pkg::div_rsp_t            div_rsp;

	logic [IDW-1:0]               rd_begin;
	logic [IDW-1:0]               rd_end;
	logic                         rd_ord;
	logic [QW-1:0]                rd_size;
	logic                         rd_skip;
	logic [IDW-1:0]               nb;
	logic [QW-1:0]                avail;
	logic                         take_all;
	logic [IDW-1:0]               ne;
	logic [QW-1:0]                quota;
	logic                         is_last_slice;
	logic [QW+drs_pkg::INDEX_W-1:0] skip_prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= drs_pkg::COUNT_W'(1);
			index_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				drs_pkg::REG_SLICE_COUNT: count_q <= wr_data;
				drs_pkg::REG_SLICE_INDEX: index_q <= wr_data[drs_pkg::INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	// load side: store and sum the incoming range
	assign ranges.ready = state_q == S_LOAD;
	assign in_fire      = ranges.valid && ranges.ready;
	assign store        = in_fire && (loaded_q < CW'(MAX_RANGES));
	assign in_size      = drs_pkg::range_size(ranges.range_begin, ranges.range_end);
	assign sum_wide     = {1'b0, total_q} + {2'b0, in_size};
	assign total_nx     = sum_wide > {1'b0, drs_pkg::TOTAL_SAT} ? drs_pkg::TOTAL_SAT
		: sum_wide[TW-1:0];

	drs_ram #(
		.WIDTH (MW),
		.DEPTH (MAX_RANGES)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (loaded_q[AW-1:0]),
		.wdata ({ranges.range_begin, ranges.range_end, ranges.range_ordered}),
		.re    (state_q == S_READ),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// share of the total per worker
	assign div_req.start    = state_q == S_CHECK && !ovalid_q
		&& {1'b0, index_q} < count_q && !total_q[TW-1];
	assign div_req.dividend = total_q[QW-1:0];
	assign div_req.divisor  = count_q;

	drs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign is_last_slice = {1'b0, index_q} + 9'd1 == count_q;
	assign skip_prod     = div_rsp.quotient * index_q;

	// trim of one stored range against skip and need
	assign rd_begin = ram_rdata[MW-1:IDW+1];
	assign rd_end   = ram_rdata[IDW:1];
	assign rd_ord   = ram_rdata[0];
	assign rd_size  = drs_pkg::range_size(rd_begin, rd_end);
	assign rd_skip  = skip_q >= rd_size;
	assign nb       = rd_begin + skip_q[IDW-1:0];
	assign avail    = rd_size - skip_q;
	assign take_all = need_q > avail;
	assign ne       = take_all ? rd_end : IDW'(nb + need_q[IDW-1:0] - 1'b1);
	assign quota    = take_all ? avail : need_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			loaded_q <= '0;
			total_q  <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && slices.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (store) begin
						loaded_q <= loaded_q + 1'b1;
						total_q  <= total_nx;
					end
					if (in_fire && ranges.last_range) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!ovalid_q) begin
						if ({1'b0, index_q} >= count_q || total_q[TW-1]) begin
							ovalid_q <= 1'b1;
							state_q  <= S_LOAD;
							loaded_q <= '0;
							total_q  <= '0;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					idx_q <= '0;
					if (div_rsp.quotient == '0 && !(is_last_slice && div_rsp.remainder != '0))
						begin
						ovalid_q <= 1'b1;
						state_q  <= S_LOAD;
						loaded_q <= '0;
						total_q  <= '0;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_PROC;
				end
				S_PROC: begin
					idx_q <= idx_q + 1'b1;
					if (rd_skip) begin
						if (idx_q + 1'b1 >= loaded_q) begin
							state_q  <= S_LOAD;
							loaded_q <= '0;
							total_q  <= '0;
						end else begin
							state_q <= S_READ;
						end
					end else begin
						ovalid_q <= 1'b1;
						if (!take_all) begin
							state_q  <= S_LOAD;
							loaded_q <= '0;
							total_q  <= '0;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (!ovalid_q) begin
						state_q <= S_READ;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// skip and need of the walk
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			skip_q <= skip_prod[QW-1:0];
			need_q <= is_last_slice
				? div_rsp.quotient + {{(QW-drs_pkg::COUNT_W){1'b0}}, div_rsp.remainder}
				: div_rsp.quotient;
		end else if (state_q == S_PROC) begin
			if (rd_skip) begin
				skip_q <= skip_q - rd_size;
			end else begin
				skip_q <= '0;
				need_q <= need_q - quota;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK && !ovalid_q && ({1'b0, index_q} >= count_q || total_q[TW-1]))
			begin
			obegin_q <= '0;
			oend_q   <= '0;
			oord_q   <= 1'b0;
			oquota_q <= '0;
			ostat_q  <= {1'b0, index_q} >= count_q ? drs_pkg::ST_INDEX : drs_pkg::ST_OVFL;
			olast_q  <= 1'b1;
		end else if (state_q == S_MUL) begin
			obegin_q <= '0;
			oend_q   <= '0;
			oord_q   <= 1'b0;
			oquota_q <= '0;
			ostat_q  <= drs_pkg::ST_EMPTY;
			olast_q  <= 1'b1;
		end else if (state_q == S_PROC && !rd_skip) begin
			obegin_q <= nb;
			oend_q   <= ne;
			oord_q   <= rd_ord;
			oquota_q <= quota;
			ostat_q  <= drs_pkg::ST_VALID;
			olast_q  <= !take_all;
		end
	end

	assign slices.valid         = ovalid_q;
	assign slices.slice_begin   = obegin_q;
	assign slices.slice_end     = oend_q;
	assign slices.slice_ordered = oord_q;
	assign slices.slice_quota   = oquota_q;
	assign slices.status        = ostat_q;
	assign slices.last_result   = olast_q;

endmodule
